>>> hw/rtl/swmlf_pkg.sv
// Shared constants for the sliding window majority label filter.
package swmlf_pkg;

   // Number of labels the window must hold before voting starts
   localparam int unsigned WARMUP_LEN = 3;

   // Widths fixed by the register map and the label fields
   localparam int unsigned LABEL_W     = 4;
   localparam int unsigned NUM_STATES_W = 5;
   localparam int unsigned WIN_LEN_W   = 6;
   localparam int unsigned CSR_DATA_W  = 6;
   localparam int unsigned CSR_INDEX_W = 1;

   // Register reset values
   localparam logic [NUM_STATES_W-1:0] NUM_STATES_RESET = 5'd16;
   localparam logic [WIN_LEN_W-1:0]    WIN_LEN_RESET    = 6'd8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NUM_STATES    = 1'b0,
      CSR_WINDOW_LENGTH = 1'b1
   } csr_index_type;

endpackage

>>> hw/rtl/sliding_window_majority_label_filter.sv
// Sliding window majority vote filter for class labels.
//
// Usage:
//   req_valid/req_ready carry one raw label per transaction (req_label).
//   rsp_valid/rsp_ready carry one filtered label per transaction
//   (rsp_filtered_label), one result for every accepted label, in order.
//   csr_wr_en/csr_index/csr_wr_data write num_states (index 0) or
//   window_length (index 1); any write clears the label history.
// Timing:
//   Throughput is one label per cycle while responses are taken. The first
//   stage updates the window and the per-state counts incrementally (one
//   label in, at most one evicted); the second runs a combinational argmax
//   tree over the registered counts into the response register. The evicted
//   label is prefetched from the window RAM into a register before its overwrite.
// Reset:
//   Synchronous reset empties the pipeline and history and restores
//   num_states = 16, window_length = 8. Window RAM contents are not cleared;
//   only slots written since the last clear are ever counted.
// Backpressure:
//   While rsp_ready is low the response holds, the middle stage fills and
//   then req_ready drops; no transaction is lost.
module sliding_window_majority_label_filter #(
   parameter int unsigned MAX_STATES = 16,
   parameter int unsigned MAX_WINDOW = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [swmlf_pkg::LABEL_W-1:0]         req_label,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [swmlf_pkg::LABEL_W-1:0]         rsp_filtered_label,
   input  logic                                  csr_wr_en,
   input  logic [swmlf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [swmlf_pkg::CSR_DATA_W-1:0]      csr_wr_data
);

   localparam int unsigned PW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int unsigned CW  = $clog2(MAX_WINDOW + 1);
   localparam int unsigned LW0 = $clog2(MAX_WINDOW + 1);
   localparam int unsigned LW  = (LW0 > swmlf_pkg::WIN_LEN_W) ? LW0 : swmlf_pkg::WIN_LEN_W;
   localparam int unsigned IW  = $clog2(MAX_STATES);
   localparam int unsigned P   = 2 ** IW;
   localparam int unsigned NODES = 2 * P - 1;

   localparam logic [LW-1:0] MAX_WIN_L = LW'(MAX_WINDOW);

   // configuration
   logic [swmlf_pkg::NUM_STATES_W-1:0] num_states_ff;
   logic [swmlf_pkg::WIN_LEN_W-1:0]    window_length_ff;
   logic [LW-1:0]                      wlen;

   // history
   logic [swmlf_pkg::LABEL_W-1:0] win_mem [MAX_WINDOW];
   logic [swmlf_pkg::LABEL_W-1:0] evict_ff;
   logic [PW-1:0]                 wp_ff, wp_in;
   logic [CW-1:0]                 fill_ff, fill_in;
   logic [CW-1:0]                 counts_ff [MAX_STATES];
   logic [CW-1:0]                 counts_in [MAX_STATES];
   logic                          full;
   logic                          clear;

   // pipeline
   logic                          accept;
   logic                          s2_free;
   logic                          s1_valid_ff, s1_valid_in;
   logic [swmlf_pkg::LABEL_W-1:0] s1_label_ff;
   logic                          s1_warm_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [swmlf_pkg::LABEL_W-1:0] rsp_label_ff, rsp_label_in;

   // argmax tree
   logic [CW-1:0] node_cnt [NODES];
   logic [IW-1:0] node_idx [NODES];
   logic          node_tie [NODES];

   assign clear   = csr_wr_en;
   assign s2_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || s2_free;
   assign accept  = req_valid && req_ready;

   // effective window length: zero acts as one, saturate at MAX_WINDOW
   always_comb begin
      priority if (window_length_ff == '0) begin
         wlen = LW'(1);
      end else if (LW'(window_length_ff) > MAX_WIN_L) begin
         wlen = MAX_WIN_L;
      end else begin
         wlen = LW'(window_length_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_states_ff    <= swmlf_pkg::NUM_STATES_RESET;
         window_length_ff <= swmlf_pkg::WIN_LEN_RESET;
      end else if (csr_wr_en) begin
         unique case (swmlf_pkg::csr_index_type'(csr_index))
            swmlf_pkg::CSR_NUM_STATES: begin
               num_states_ff <= csr_wr_data[swmlf_pkg::NUM_STATES_W-1:0];
            end
            swmlf_pkg::CSR_WINDOW_LENGTH: begin
               window_length_ff <= csr_wr_data[swmlf_pkg::WIN_LEN_W-1:0];
            end
         endcase
      end
   end

   assign full = (LW'(fill_ff) == wlen);

   always_comb begin
      logic [LW-1:0] wp_next;
      wp_next = LW'(wp_ff) + LW'(1);
      wp_in   = wp_ff;
      fill_in = fill_ff;
      if (clear) begin
         wp_in   = '0;
         fill_in = '0;
      end else if (accept) begin
         wp_in = (wp_next >= wlen) ? '0 : wp_next[PW-1:0];
         if (!full) begin
            fill_in = fill_ff + CW'(1);
         end
      end
   end

   // incremental histogram: add the new label, drop the evicted one once full
   always_comb begin
      logic inc;
      logic dec;
      logic new_counted;
      logic old_counted;
      new_counted = ({1'b0, req_label} < num_states_ff);
      old_counted = ({1'b0, evict_ff} < num_states_ff) && full;
      for (int i = 0; i < MAX_STATES; i++) begin
         inc = new_counted && (32'(req_label) == 32'(i));
         dec = old_counted && (32'(evict_ff) == 32'(i));
         counts_in[i] = counts_ff[i];
         if (clear) begin
            counts_in[i] = '0;
         end else if (accept) begin
            counts_in[i] = counts_ff[i] + CW'(inc) - CW'(dec);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         fill_ff <= '0;
         for (int i = 0; i < MAX_STATES; i++) begin
            counts_ff[i] <= '0;
         end
      end else begin
         wp_ff   <= wp_in;
         fill_ff <= fill_in;
         for (int i = 0; i < MAX_STATES; i++) begin
            counts_ff[i] <= counts_in[i];
         end
      end
   end

   // window RAM; read port prefetches the slot the next label overwrites
   always_ff @(posedge clock) begin
      if (accept) begin
         win_mem[wp_ff] <= req_label;
      end
      evict_ff <= win_mem[wp_in];
   end

   // stage 1: holds the label whose counts sit in counts_ff
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s2_free) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (accept) begin
         s1_label_ff <= req_label;
         s1_warm_ff  <= (32'(fill_in) < swmlf_pkg::WARMUP_LEN);
      end
   end

   // argmax with tie flag, leaves padded with zero counts
   always_comb begin
      for (int i = 0; i < P; i++) begin
         node_idx[P-1+i] = IW'(i);
         node_tie[P-1+i] = 1'b0;
         node_cnt[P-1+i] = (i < MAX_STATES) ? counts_ff[i] : '0;
      end
      for (int n = P - 2; n >= 0; n--) begin
         if (node_cnt[2*n+1] > node_cnt[2*n+2]) begin
            node_cnt[n] = node_cnt[2*n+1];
            node_idx[n] = node_idx[2*n+1];
            node_tie[n] = node_tie[2*n+1];
         end else if (node_cnt[2*n+2] > node_cnt[2*n+1]) begin
            node_cnt[n] = node_cnt[2*n+2];
            node_idx[n] = node_idx[2*n+2];
            node_tie[n] = node_tie[2*n+2];
         end else begin
            node_cnt[n] = node_cnt[2*n+1];
            node_idx[n] = node_idx[2*n+1];
            node_tie[n] = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_label_in = rsp_label_ff;
      if (s2_free) begin
         rsp_valid_in = s1_valid_ff;
         if (s1_warm_ff || node_tie[0] || (node_cnt[0] == '0)) begin
            rsp_label_in = s1_label_ff;
         end else begin
            rsp_label_in = swmlf_pkg::LABEL_W'(node_idx[0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_label_ff <= rsp_label_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_label = rsp_label_ff;

endmodule
